>>> hw/rtl/erp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erp_pkg
// Shared constants, codes and the matrix build program for the Euler
// rotation block.
// ---------------------------------------------------------------------------
package erp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_FRAC_DEF   = 15;

    // configuration port
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd2;

    // Taylor series unit
    localparam int ANGLE_FRAC   = 13;
    localparam int TRIG_FRAC    = 42;
    localparam int MID_FRAC     = 30;
    localparam int TAYLOR_TERMS = 40;
    localparam int TERM_W       = 47;
    localparam int TPROD_W      = TERM_W + ANGLE_W;
    localparam int DIVD_W       = TPROD_W - ANGLE_FRAC;
    localparam int DIV_CNT_W    = $clog2(DIVD_W);
    localparam int N_W          = $clog2(TAYLOR_TERMS + 1);
    localparam int SUM_W        = 49;

    // matrix build
    localparam int MID_W   = 32;
    localparam int MPROD_W = 2 * MID_W;
    localparam int MRND_W  = MPROD_W - MID_FRAC;
    localparam int MACC_W  = MRND_W + 1;
    localparam int MAT_N   = 9;
    localparam int STEP_N  = 15;
    localparam int STEP_W  = $clog2(STEP_N);

    localparam int SEL_W = 4;
    localparam logic [SEL_W-1:0] SEL_SA   = 4'd0;
    localparam logic [SEL_W-1:0] SEL_CA   = 4'd1;
    localparam logic [SEL_W-1:0] SEL_SB   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_CB   = 4'd3;
    localparam logic [SEL_W-1:0] SEL_SG   = 4'd4;
    localparam logic [SEL_W-1:0] SEL_CG   = 4'd5;
    localparam logic [SEL_W-1:0] SEL_SBCG = 4'd6;
    localparam logic [SEL_W-1:0] SEL_SBSG = 4'd7;
    localparam logic [SEL_W-1:0] SEL_ONE  = 4'd8;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 2'd2;
    localparam logic [OP_W-1:0] OP_NEG  = 2'd3;

    // destinations 0..8 are coefficient slots, row-major
    localparam int DST_W = 4;
    localparam logic [DST_W-1:0] DST_SBCG = 4'd9;
    localparam logic [DST_W-1:0] DST_SBSG = 4'd10;
    localparam logic [DST_W-1:0] DST_NONE = 4'd15;

    typedef struct packed {
        logic [SEL_W-1:0] a;
        logic [SEL_W-1:0] b;
        logic [OP_W-1:0]  op;
        logic [DST_W-1:0] dst;
    } mstep_t;

    function automatic mstep_t mat_step(input logic [STEP_W-1:0] idx);
        mstep_t s;
        case (idx)
            4'd0:    s = '{SEL_SB, SEL_CG,   OP_LOAD, DST_SBCG};
            4'd1:    s = '{SEL_SB, SEL_SG,   OP_LOAD, DST_SBSG};
            4'd2:    s = '{SEL_CB, SEL_CG,   OP_LOAD, 4'd0};
            4'd3:    s = '{SEL_SA, SEL_SBCG, OP_LOAD, DST_NONE};
            4'd4:    s = '{SEL_CA, SEL_SG,   OP_ADD,  4'd1};
            4'd5:    s = '{SEL_SA, SEL_SG,   OP_LOAD, DST_NONE};
            4'd6:    s = '{SEL_CA, SEL_SBCG, OP_SUB,  4'd2};
            4'd7:    s = '{SEL_CB, SEL_SG,   OP_NEG,  4'd3};
            4'd8:    s = '{SEL_CA, SEL_CG,   OP_LOAD, DST_NONE};
            4'd9:    s = '{SEL_SA, SEL_SBSG, OP_SUB,  4'd4};
            4'd10:   s = '{SEL_SA, SEL_CG,   OP_LOAD, DST_NONE};
            4'd11:   s = '{SEL_CA, SEL_SBSG, OP_ADD,  4'd5};
            4'd12:   s = '{SEL_SB, SEL_ONE,  OP_LOAD, 4'd6};
            4'd13:   s = '{SEL_SA, SEL_CB,   OP_NEG,  4'd7};
            default: s = '{SEL_CA, SEL_CB,   OP_LOAD, 4'd8};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/euler_rotate_point3_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// euler_rotate_point3_core
// Rotates a stream of 3D points by a matrix built from three Euler angles.
// ---------------------------------------------------------------------------
// Points stream at one item per cycle while point_stall is low; a
// three-stage pipeline (input, products, round/saturate) with a register
// per stage lets items keep entering while a result waits.
// After reset the matrix is the identity. Each angle write starts a rebuild
// of the nine coefficients, paced by the Taylor unit's one-bit-per-cycle
// divider (3 angles x 40 terms, then rounding and the matrix products on
// one shared multiplier); point_stall and cfg_ready hold off new items and
// writes until it ends.
// ---------------------------------------------------------------------------
module euler_rotate_point3_core
    import erp_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [CFG_IDX_W-1:0]        cfg_index,
    input  wire  [ANGLE_W-1:0]          cfg_data,
    input  wire                         point_valid,
    output logic                        point_stall,
    input  wire  signed [COORD_WIDTH-1:0] point_x,
    input  wire  signed [COORD_WIDTH-1:0] point_y,
    input  wire  signed [COORD_WIDTH-1:0] point_z,
    output logic                        result_valid,
    input  wire                         result_stall,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z,
    output logic                        clipped
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = W + CW;
    localparam int SW = PW + 2;

    localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] TOP_V    = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] BOT_V    = -(SW'(1) << (W - 1));
    localparam logic signed [W-1:0]  TOP_W    = W'(TOP_V);
    localparam logic signed [W-1:0]  BOT_W    = W'(BOT_V);

    logic                   gen_busy;
    logic signed [CW-1:0]   coef [MAT_N];

    logic                   v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic signed [W-1:0]    pt_reg [3];
    logic signed [PW-1:0]   prod_reg [MAT_N];
    logic signed [PW-1:0]   prod_next [MAT_N];
    logic signed [W-1:0]    rot_reg [3];
    logic signed [W-1:0]    rot_next [3];
    logic                   clip_reg, clip_next;
    logic                   adv1, adv2, adv3;
    logic signed [SW-1:0]   row_sum [3];
    logic signed [SW-1:0]   row_val [3];

    erp_coef_gen #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (gen_busy),
        .coef      (coef)
    );

    // advance a stage when the next one is empty or moving on
    assign adv3        = v2_reg && (!v3_reg || !result_stall);
    assign adv2        = v1_reg && (!v2_reg || adv3);
    assign point_stall = gen_busy || (v1_reg && !adv2);
    assign adv1        = point_valid && !point_stall;

    always_comb
    begin
        v1_next = adv1 ? 1'b1 : (adv2 ? 1'b0 : v1_reg);
        v2_next = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_reg);
        v3_next = adv3 ? 1'b1 : (result_stall ? v3_reg : 1'b0);

        for (int i = 0; i < MAT_N; i++)
            prod_next[i] = PW'(coef[i]) * PW'(pt_reg[i % 3]);

        clip_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = SW'(prod_reg[3*r]) + SW'(prod_reg[3*r+1])
                       + SW'(prod_reg[3*r+2]);
            row_val[r] = (row_sum[r] + RND_HALF) >>> COEF_FRAC_BITS;
            if (row_val[r] > TOP_V)
            begin
                rot_next[r] = TOP_W;
                clip_next   = 1'b1;
            end
            else if (row_val[r] < BOT_V)
            begin
                rot_next[r] = BOT_W;
                clip_next   = 1'b1;
            end
            else
                rot_next[r] = W'(row_val[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
        end
        if (adv2)
            prod_reg <= prod_next;
        if (adv3)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign result_valid = v3_reg;
    assign rotated_x    = rot_reg[0];
    assign rotated_y    = rot_reg[1];
    assign rotated_z    = rot_reg[2];
    assign clipped      = clip_reg;

    // an angle write must start a rebuild
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index <= CFG_GAMMA) |=> gen_busy)
        else $error("angle write did not start coefficient rebuild");

    // a flagged result sits on a saturation bound
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && clipped |->
            (rotated_x == TOP_W || rotated_x == BOT_W ||
             rotated_y == TOP_W || rotated_y == BOT_W ||
             rotated_z == TOP_W || rotated_z == BOT_W))
        else $error("clipped set without a saturated coordinate");

    // an accepted item lands in the input stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> v1_reg)
        else $error("accepted item lost at input stage");

endmodule
`default_nettype wire

>>> hw/rtl/erp_coef_gen.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erp_coef_gen
// Holds the three angles and rebuilds the nine rotation coefficients after
// each angle write: Taylor sine/cosine with a bit-serial divider, then a
// short multiply-accumulate program for the matrix.
// ---------------------------------------------------------------------------
module erp_coef_gen
    import erp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
    localparam int CW = COEF_FRAC_BITS + 2
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [CFG_IDX_W-1:0]        cfg_index,
    input  wire  [ANGLE_W-1:0]          cfg_data,
    output logic                        busy,
    output logic signed [CW-1:0]        coef [MAT_N]
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_MMUL = 3'd5;
    localparam logic [2:0] ST_MACC = 3'd6;

    localparam int TRIG_SH = TRIG_FRAC - MID_FRAC;
    localparam int COEF_SH = MID_FRAC - COEF_FRAC_BITS;

    localparam logic [TERM_W-1:0]       TERM_ONE = TERM_W'(1) << TRIG_FRAC;
    localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(1) << TRIG_FRAC;
    localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (TRIG_SH - 1);
    localparam logic signed [MPROD_W-1:0] MP_HALF = MPROD_W'(1) << (MID_FRAC - 1);
    localparam logic signed [MACC_W-1:0]  CF_HALF = MACC_W'(1) << (COEF_SH - 1);
    localparam logic signed [MID_W-1:0]   MID_ONE = MID_W'(1) << MID_FRAC;
    localparam logic signed [CW-1:0]      CF_ONE  = CW'(1) << COEF_FRAC_BITS;

    logic [2:0]                 state_reg, state_next;
    logic [1:0]                 ang_sel_reg, ang_sel_next;
    logic signed [ANGLE_W-1:0]  alpha_reg, alpha_next;
    logic signed [ANGLE_W-1:0]  beta_reg, beta_next;
    logic signed [ANGLE_W-1:0]  gamma_reg, gamma_next;
    logic [TERM_W-1:0]          term_reg, term_next;
    logic [N_W-1:0]             n_reg, n_next;
    logic signed [SUM_W-1:0]    sin_acc_reg, sin_acc_next;
    logic signed [SUM_W-1:0]    cos_acc_reg, cos_acc_next;
    logic [TPROD_W-1:0]         tprod_reg, tprod_next;
    logic [DIVD_W-1:0]          div_reg, div_next;
    logic [N_W-1:0]             rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [MID_W-1:0]    sa_reg, sa_next, ca_reg, ca_next;
    logic signed [MID_W-1:0]    sb_reg, sb_next, cb_reg, cb_next;
    logic signed [MID_W-1:0]    sg_reg, sg_next, cg_reg, cg_next;
    logic signed [MID_W-1:0]    sbcg_reg, sbcg_next, sbsg_reg, sbsg_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic signed [MPROD_W-1:0]  mprod_reg, mprod_next;
    logic signed [MACC_W-1:0]   macc_reg, macc_next;
    logic signed [CW-1:0]       coef_reg [MAT_N];
    logic signed [CW-1:0]       coef_next [MAT_N];

    logic signed [ANGLE_W-1:0]  ang_cur;
    logic [ANGLE_W-1:0]         ang_mag;
    logic [N_W:0]               rem_try;
    logic signed [SUM_W-1:0]    sin_rnd, cos_rnd;
    logic signed [MID_W-1:0]    sin_out, cos_out;
    mstep_t                     step;
    logic signed [MID_W-1:0]    opnd_a, opnd_b;
    logic signed [MRND_W-1:0]   mrnd;
    logic signed [MACC_W-1:0]   macc_new;
    logic signed [MACC_W-1:0]   coef_wide;

    function automatic logic signed [MID_W-1:0] pick(
        input logic [SEL_W-1:0] sel,
        input logic signed [MID_W-1:0] sa, ca, sb, cb, sg, cg, sbcg, sbsg,
        input logic signed [MID_W-1:0] one);
        logic signed [MID_W-1:0] v;
        unique case (sel)
            SEL_SA:   v = sa;
            SEL_CA:   v = ca;
            SEL_SB:   v = sb;
            SEL_CB:   v = cb;
            SEL_SG:   v = sg;
            SEL_CG:   v = cg;
            SEL_SBCG: v = sbcg;
            SEL_SBSG: v = sbsg;
            default:  v = one;
        endcase
        return v;
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign coef      = coef_reg;

    always_comb
    begin
        unique case (ang_sel_reg)
            2'd0:    ang_cur = alpha_reg;
            2'd1:    ang_cur = beta_reg;
            default: ang_cur = gamma_reg;
        endcase
        ang_mag = ang_cur[ANGLE_W-1] ? ANGLE_W'(-ang_cur) : ang_cur;
        rem_try = {rem_reg, div_reg[DIVD_W-1]};
        sin_rnd = (sin_acc_reg + SUM_HALF) >>> TRIG_SH;
        cos_rnd = (cos_acc_reg + SUM_HALF) >>> TRIG_SH;
        sin_out = ang_cur[ANGLE_W-1] ? -MID_W'(sin_rnd) : MID_W'(sin_rnd);
        cos_out = MID_W'(cos_rnd);

        step   = mat_step(step_reg);
        opnd_a = pick(step.a, sa_reg, ca_reg, sb_reg, cb_reg, sg_reg, cg_reg,
                      sbcg_reg, sbsg_reg, MID_ONE);
        opnd_b = pick(step.b, sa_reg, ca_reg, sb_reg, cb_reg, sg_reg, cg_reg,
                      sbcg_reg, sbsg_reg, MID_ONE);
        mrnd   = MRND_W'((mprod_reg + MP_HALF) >>> MID_FRAC);
        case (step.op)
            OP_LOAD: macc_new = MACC_W'(mrnd);
            OP_ADD:  macc_new = macc_reg + MACC_W'(mrnd);
            OP_SUB:  macc_new = macc_reg - MACC_W'(mrnd);
            default: macc_new = -MACC_W'(mrnd);
        endcase
        coef_wide = (macc_new + CF_HALF) >>> COEF_SH;

        state_next   = state_reg;
        ang_sel_next = ang_sel_reg;
        alpha_next   = alpha_reg;
        beta_next    = beta_reg;
        gamma_next   = gamma_reg;
        term_next    = term_reg;
        n_next       = n_reg;
        sin_acc_next = sin_acc_reg;
        cos_acc_next = cos_acc_reg;
        tprod_next   = tprod_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        sa_next      = sa_reg;
        ca_next      = ca_reg;
        sb_next      = sb_reg;
        cb_next      = cb_reg;
        sg_next      = sg_reg;
        cg_next      = cg_reg;
        sbcg_next    = sbcg_reg;
        sbsg_next    = sbsg_reg;
        step_next    = step_reg;
        mprod_next   = mprod_reg;
        macc_next    = macc_reg;
        coef_next    = coef_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid && (cfg_index <= CFG_GAMMA))
                begin
                    unique case (cfg_index)
                        CFG_ALPHA: alpha_next = cfg_data;
                        CFG_BETA:  beta_next  = cfg_data;
                        default:   gamma_next = cfg_data;
                    endcase
                    ang_sel_next = 2'd0;
                    term_next    = TERM_ONE;
                    n_next       = N_W'(1);
                    sin_acc_next = '0;
                    cos_acc_next = SUM_ONE;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                tprod_next = TPROD_W'(term_reg) * TPROD_W'(ang_mag);
                state_next = ST_DIV;
                div_next   = tprod_next[TPROD_W-1:ANGLE_FRAC];
                rem_next   = '0;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                // restoring divide by the term number, one quotient bit a cycle
                if (rem_try >= {1'b0, n_reg})
                begin
                    rem_next = N_W'(rem_try - {1'b0, n_reg});
                    div_next = {div_reg[DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try[N_W-1:0];
                    div_next = {div_reg[DIVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1))
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                term_next = div_reg[TERM_W-1:0];
                case (n_reg[1:0])
                    2'd1:    sin_acc_next = sin_acc_reg + SUM_W'(term_next);
                    2'd2:    cos_acc_next = cos_acc_reg - SUM_W'(term_next);
                    2'd3:    sin_acc_next = sin_acc_reg - SUM_W'(term_next);
                    default: cos_acc_next = cos_acc_reg + SUM_W'(term_next);
                endcase
                if (n_reg == N_W'(TAYLOR_TERMS))
                    state_next = ST_FIN;
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                unique case (ang_sel_reg)
                    2'd0:    begin sa_next = sin_out; ca_next = cos_out; end
                    2'd1:    begin sb_next = sin_out; cb_next = cos_out; end
                    default: begin sg_next = sin_out; cg_next = cos_out; end
                endcase
                term_next    = TERM_ONE;
                n_next       = N_W'(1);
                sin_acc_next = '0;
                cos_acc_next = SUM_ONE;
                step_next    = '0;
                if (ang_sel_reg == 2'd2)
                    state_next = ST_MMUL;
                else
                begin
                    ang_sel_next = ang_sel_reg + 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MMUL:
            begin
                mprod_next = MPROD_W'(opnd_a) * MPROD_W'(opnd_b);
                state_next = ST_MACC;
            end
            ST_MACC:
            begin
                macc_next = macc_new;
                if (step.dst == DST_SBCG)
                    sbcg_next = MID_W'(macc_new);
                else if (step.dst == DST_SBSG)
                    sbsg_next = MID_W'(macc_new);
                else if (step.dst < DST_W'(MAT_N))
                    coef_next[step.dst] = CW'(coef_wide);
                if (step_reg == STEP_W'(STEP_N - 1))
                    state_next = ST_IDLE;
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MMUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ang_sel_reg <= 2'd0;
            alpha_reg   <= '0;
            beta_reg    <= '0;
            gamma_reg   <= '0;
            for (int i = 0; i < MAT_N; i++)
                coef_reg[i] <= (i % 4 == 0) ? CF_ONE : '0;
        end
        else
        begin
            state_reg   <= state_next;
            ang_sel_reg <= ang_sel_next;
            alpha_reg   <= alpha_next;
            beta_reg    <= beta_next;
            gamma_reg   <= gamma_next;
            coef_reg    <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg    <= term_next;
        n_reg       <= n_next;
        sin_acc_reg <= sin_acc_next;
        cos_acc_reg <= cos_acc_next;
        tprod_reg   <= tprod_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        sa_reg      <= sa_next;
        ca_reg      <= ca_next;
        sb_reg      <= sb_next;
        cb_reg      <= cb_next;
        sg_reg      <= sg_next;
        cg_reg      <= cg_next;
        sbcg_reg    <= sbcg_next;
        sbsg_reg    <= sbsg_next;
        step_reg    <= step_next;
        mprod_reg   <= mprod_next;
        macc_reg    <= macc_next;
    end

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Testbench for euler_rotate_point3_core: drives points and angle writes,
// predicts each rotated point in fixed point and checks it field by field.
// ---------------------------------------------------------------------------
module tb;
    import erp_pkg::*;

    localparam int  CW          = 32;
    localparam int  CF          = 15;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          clip;
    } rotated_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ANGLE_W-1:0]   cfg_data;
    logic                 point_valid;
    logic                 point_stall;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 result_valid;
    logic                 result_stall;
    logic signed [CW-1:0] rotated_x;
    logic signed [CW-1:0] rotated_y;
    logic signed [CW-1:0] rotated_z;
    logic                 clipped;

    rotated_t rotated_q[$];
    longint   angle_reg[3];
    longint   coef[9];
    int       src_idle_pct;
    int       dst_stall_pct;
    bit       hold_go;
    logic     hold_on;
    int       errors;
    longint   cycles;

    euler_rotate_point3_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .point_valid(point_valid), .point_stall(point_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .result_valid(result_valid), .result_stall(result_stall),
        .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
        .clipped(clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // round to nearest, ties toward plus infinity
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void sin_cos(input longint k, output longint sn, output longint cs);
        longint unsigned m;
        longint unsigned t;
        longint s;
        longint c;
        m = (k < 0) ? -k : k;
        t = 64'd1 << TRIG_FRAC;
        s = 0;
        c = t;
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            t = (t * m) / (longint'(n) << ANGLE_FRAC);
            case (n % 4)
                1: s += t;
                2: c -= t;
                3: s -= t;
                default: c += t;
            endcase
        end
        s = rnd_shift(s, TRIG_FRAC - MID_FRAC);
        c = rnd_shift(c, TRIG_FRAC - MID_FRAC);
        sn = (k < 0) ? -s : s;
        cs = c;
    endfunction

    function automatic longint mmul(input longint a, input longint b);
        return rnd_shift(a * b, MID_FRAC);
    endfunction

    function automatic longint to_coef(input longint v);
        return rnd_shift(v, MID_FRAC - CF);
    endfunction

    function automatic void build_coefficients();
        longint sa, ca, sb, cb, sg, cg, sbcg, sbsg;
        sin_cos(angle_reg[0], sa, ca);
        sin_cos(angle_reg[1], sb, cb);
        sin_cos(angle_reg[2], sg, cg);
        sbcg = mmul(sb, cg);
        sbsg = mmul(sb, sg);
        coef[0] = to_coef(mmul(cb, cg));
        coef[1] = to_coef(mmul(sa, sbcg) + mmul(ca, sg));
        coef[2] = to_coef(mmul(sa, sg) - mmul(ca, sbcg));
        coef[3] = to_coef(-mmul(cb, sg));
        coef[4] = to_coef(mmul(ca, cg) - mmul(sa, sbsg));
        coef[5] = to_coef(mmul(sa, cg) + mmul(ca, sbsg));
        coef[6] = to_coef(sb);
        coef[7] = to_coef(-mmul(sa, cb));
        coef[8] = to_coef(mmul(ca, cb));
    endfunction

    function automatic rotated_t rotate_point(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] z);
        longint   hi[3];
        longint   lo[3];
        longint   c;
        longint   a;
        longint   b;
        longint   v[3];
        longint   top;
        rotated_t r;
        top = (64'sd1 <<< (CW - 1)) - 1;
        r.clip = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            c = (j == 0) ? longint'(x) : (j == 1) ? longint'(y) : longint'(z);
            lo[j] = c & ((64'sd1 <<< CF) - 1);
            hi[j] = c >>> CF;
        end
        for (int i = 0; i < 3; i++)
        begin
            a = 0;
            b = 0;
            for (int j = 0; j < 3; j++)
            begin
                a += coef[i*3+j] * hi[j];
                b += coef[i*3+j] * lo[j];
            end
            v[i] = a + rnd_shift(b, CF);
            if (v[i] > top)
            begin
                v[i] = top;
                r.clip = 1'b1;
            end
            else if (v[i] < -top - 1)
            begin
                v[i] = -top - 1;
                r.clip = 1'b1;
            end
        end
        r.x = v[0][CW-1:0];
        r.y = v[1][CW-1:0];
        r.z = v[2][CW-1:0];
        return r;
    endfunction

    // entered at a clock edge right after the previous item was taken
    task automatic send_point(input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y,
                              input logic signed [CW-1:0] z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        rotated_q.push_back(rotate_point(x, y, z));
        do @(posedge clk); while (point_stall);
    endtask

    task automatic write_angle(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
        point_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
        // let the pipeline drain fully
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= CFG_GAMMA)
        begin
            angle_reg[idx] = longint'($signed(data));
            build_coefficients();
        end
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return CW'($signed($urandom_range(4194304)) - 2097152);
            2: return {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom)};
            default: return CW'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    task automatic test_identity();
        logic signed [CW-1:0] ext[6];
        ext = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh00010000};
        for (int i = 0; i < 6; i++)
            send_point(ext[i], ext[(i+2)%6], ext[(i+4)%6]);
    endtask

    task automatic test_angles();
        // quarter turn, angle extremes, out-of-range index ignored
        write_angle(CFG_ALPHA, 16'd12868);
        send_point(32'sh00010000, 32'sh00020000, 32'sh00030000);
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        write_angle(CFG_BETA, 16'sh7fff);
        write_angle(CFG_GAMMA, 16'sh8000);
        send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_point(-1, 1, 0);
        write_angle(2'd3, 16'd6434);
        send_point(32'sh40000000, -32'sh40000000, 32'sh12345678);
        write_angle(CFG_ALPHA, 16'd6434);
        send_point(32'sh7fffffff, 32'sh7fffffff, 0);
        send_point(32'sh80000000, 0, 32'sh80000000);
    endtask

    task automatic test_random(input int n, input int sidle, input int dstall, input bit press);
        src_idle_pct  = sidle;
        dst_stall_pct = dstall;
        for (int i = 0; i < n; i++)
        begin
            if (i % 170 == 0)
                write_angle(CFG_IDX_W'($urandom_range(2)),
                            ($urandom_range(5) == 0) ? 16'(32767 + $urandom_range(1))
                                                    : 16'($urandom));
            if (press && i == n / 2)
                hold_go = 1'b1;
            send_point(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_on <= 1'b1;
                repeat (400) @(posedge clk);
                hold_on <= 1'b0;
                hold_go = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    $display("%0t: unexpected item x=%h y=%h z=%h clip=%b", $time,
                             rotated_x, rotated_y, rotated_z, clipped);
                    errors++;
                end
                else
                begin
                    rotated_t e;
                    e = rotated_q.pop_front();
                    if (rotated_x !== e.x)
                    begin
                        $display("%0t: rotated_x exp %h got %h", $time, e.x, rotated_x);
                        errors++;
                    end
                    if (rotated_y !== e.y)
                    begin
                        $display("%0t: rotated_y exp %h got %h", $time, e.y, rotated_y);
                        errors++;
                    end
                    if (rotated_z !== e.z)
                    begin
                        $display("%0t: rotated_z exp %h got %h", $time, e.z, rotated_z);
                        errors++;
                    end
                    if (clipped !== e.clip)
                    begin
                        $display("%0t: clipped exp %b got %b", $time, e.clip, clipped);
                        errors++;
                    end
                end
            end
            result_stall <= hold_on || ($urandom_range(99) < dst_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        cycles        = 0;
        hold_go       = 1'b0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        point_valid   = 1'b0;
        point_x       = '0;
        point_y       = '0;
        point_z       = '0;
        result_stall  = 1'b0;
        angle_reg     = '{0, 0, 0};
        build_coefficients();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity();
        test_angles();
        test_random(520, 19, 76, 1'b0);
        test_random(520, 76, 19, 1'b0);
        test_random(510, 0, 0, 1'b1);

        point_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
